FILE: rtl/jsu_pkg.sv
// jsu_pkg: shared types, codes and decode helpers for the json string unescaper
// used by json_string_unescape_utf8_core; no dependencies
package jsu_pkg;

	localparam int LENGTH_WIDTH_DEF = 16;
	localparam int MAX_RESULTS      = 5;
	localparam int LEN_OUT_W        = 16;

	localparam logic [1:0] ST_DATA = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	localparam logic [3:0] M_IDLE    = 4'd0;
	localparam logic [3:0] M_STR     = 4'd1;
	localparam logic [3:0] M_ESC     = 4'd2;
	localparam logic [3:0] M_HI0     = 4'd3;
	localparam logic [3:0] M_HI1     = 4'd4;
	localparam logic [3:0] M_HI2     = 4'd5;
	localparam logic [3:0] M_HI3     = 4'd6;
	localparam logic [3:0] M_WAIT_BS = 4'd7;
	localparam logic [3:0] M_WAIT_U  = 4'd8;
	localparam logic [3:0] M_LO0     = 4'd9;
	localparam logic [3:0] M_LO1     = 4'd10;
	localparam logic [3:0] M_LO2     = 4'd11;
	localparam logic [3:0] M_LO3     = 4'd12;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;

	localparam logic [15:0] HI_SURR_LO = 16'hD800;
	localparam logic [15:0] HI_SURR_HI = 16'hDBFF;
	// 0x10000 - 0xDC00, the fixed part of the surrogate pair combine
	localparam logic [20:0] PAIR_BASE  = 21'h02400;

	typedef struct packed {
		logic [7:0]           data;
		logic [1:0]           status;
		logic [LEN_OUT_W-1:0] length;
		logic                 last;
	} res_t;

	typedef struct packed {
		logic       mid_v;
		logic [1:0] mid_st;
		logic [7:0] mid_data;
		logic [3:0] mode;
		logic       acc_clr;
	} act_t;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      n;
	} utf8_t;

	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'b0;
		if (c inside {[8'h30:8'h39]})
			r = {1'b1, 4'(c - 8'h30)};
		else if (c inside {[8'h61:8'h66]})
			r = {1'b1, 4'(c - 8'h57)};
		else if (c inside {[8'h41:8'h46]})
			r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	function automatic utf8_t utf8_enc(input logic [20:0] cp);
		utf8_t r;
		r = '0;
		if (cp < 21'h80) begin
			r.n    = 3'd1;
			r.b[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			r.n    = 3'd2;
			r.b[0] = {3'b110, cp[10:6]};
			r.b[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			r.n    = 3'd3;
			r.b[0] = {4'b1110, cp[15:12]};
			r.b[1] = {2'b10, cp[11:6]};
			r.b[2] = {2'b10, cp[5:0]};
		end else begin
			r.n    = 3'd4;
			r.b[0] = {5'b11110, cp[20:18]};
			r.b[1] = {2'b10, cp[17:12]};
			r.b[2] = {2'b10, cp[11:6]};
			r.b[3] = {2'b10, cp[5:0]};
		end
		return r;
	endfunction

	function automatic act_t err_act();
		act_t a;
		a.mid_v    = 1'b1;
		a.mid_st   = ST_ERR;
		a.mid_data = 8'h00;
		a.mode     = M_IDLE;
		a.acc_clr  = 1'b0;
		return a;
	endfunction

	function automatic act_t plain_act(input logic [7:0] c);
		act_t a;
		a.mid_v    = 1'b1;
		a.mid_st   = ST_DATA;
		a.mid_data = c;
		a.mode     = M_STR;
		a.acc_clr  = 1'b0;
		if (c == CH_QUOTE) begin
			a.mid_st   = ST_DONE;
			a.mid_data = 8'h00;
			a.mode     = M_IDLE;
		end else if (c == CH_BSLASH) begin
			a.mid_v = 1'b0;
			a.mode  = M_ESC;
		end
		return a;
	endfunction

	function automatic act_t escape_act(input logic [7:0] c);
		act_t a;
		a.mid_v    = 1'b1;
		a.mid_st   = ST_DATA;
		a.mid_data = c;
		a.mode     = M_STR;
		a.acc_clr  = 1'b0;
		case (c)
			CH_QUOTE, CH_BSLASH, CH_SLASH: a.mid_data = c;
			CH_B: a.mid_data = 8'h08;
			CH_F: a.mid_data = 8'h0C;
			CH_N: a.mid_data = 8'h0A;
			CH_R: a.mid_data = 8'h0D;
			CH_T: a.mid_data = 8'h09;
			CH_U: begin
				a.mid_v   = 1'b0;
				a.mode    = M_HI0;
				a.acc_clr = 1'b1;
			end
			default: a = err_act();
		endcase
		return a;
	endfunction

endpackage

FILE: rtl/json_string_unescape_utf8_core.sv
// json_string_unescape_utf8_core: json string literal unescaper, raw bytes in,
// utf-8 decoded bytes plus done/error status out
// depends on jsu_pkg
//
// Usage: the item channel (item_valid/item_ready) takes one raw byte per beat,
// with begin_req on the opening quote of a string and end_of_text on the last
// byte of the buffer. The result channel (result_valid/result_ready) gives one
// result per beat: a decoded byte, a done marker with the decoded length, or
// an error; last marks the final result caused by an input byte. An input byte
// gives 0 to 5 results. Each byte is decoded in the cycle it is accepted and
// its results are held in a five-entry result buffer that drains into the
// output register that drives result_valid.
// A byte is accepted while the buffer holds at most one result that is
// leaving, so with one result per byte and no stall a byte is taken every
// cycle; a byte with k results keeps item_ready low until only its last
// result is leaving. Bytes that give no result are taken every cycle.
// Reset returns the decoder to idle and empties the buffer and output register.
// When the receiver stalls, the output register holds, the buffer fills, and
// item_ready drops until the buffer can drain.
module json_string_unescape_utf8_core
	import jsu_pkg::*;
#(
	parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic [7:0]           data_byte,
	input  logic                 begin_req,
	input  logic                 end_of_text,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [7:0]           out_byte,
	output logic [1:0]           status,
	output logic [LEN_OUT_W-1:0] decoded_length,
	output logic                 last
);

	localparam int PTR_W = $clog2(MAX_RESULTS);
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);

	logic [3:0]              mode_q;
	logic [15:0]             acc_q;
	logic [15:0]             hs_q;
	logic [LENGTH_WIDTH-1:0] len_q;

	res_t                    pend_q [MAX_RESULTS];
	logic [CNT_W-1:0]        pend_cnt_q;
	logic [PTR_W-1:0]        pend_rd_q;
	res_t                    out_q;
	logic                    out_valid_q;

	logic                    accept;
	logic                    out_load;
	logic                    pend_pop;

	act_t                    act;
	logic [15:0]             acc_n;
	logic [15:0]             hs_n;
	logic                    len_rst;
	logic [4:0]              hx;
	logic [15:0]             acc_sh;
	logic [20:0]             cp_pair;
	logic [20:0]             enc_src;
	logic                    enc_on;
	utf8_t                   enc;
	logic [2:0]              enc_n;
	logic                    eot_err;
	logic [2:0]              res_n;
	logic [2:0]              data_n;
	logic [LENGTH_WIDTH:0]   done_sum;
	logic [LENGTH_WIDTH:0]   next_sum;
	logic [LENGTH_WIDTH-1:0] done_len;
	logic [LENGTH_WIDTH-1:0] len_n;
	logic [LENGTH_WIDTH+LEN_OUT_W-1:0] done_ext;
	res_t                    res_list [MAX_RESULTS];

	localparam logic [LENGTH_WIDTH:0] LEN_MAX = {1'b0, {LENGTH_WIDTH{1'b1}}};

	assign out_load     = !out_valid_q || result_ready;
	assign pend_pop     = out_load && (pend_cnt_q != '0);
	assign item_ready   = (pend_cnt_q == '0) ||
	                      ((pend_cnt_q == CNT_W'(1)) && out_load);
	assign accept       = item_valid && item_ready;

	assign result_valid   = out_valid_q;
	assign out_byte       = out_q.data;
	assign status         = out_q.status;
	assign decoded_length = out_q.length;
	assign last           = out_q.last;

	// byte decode
	always_comb begin
		act     = '0;
		act.mode = mode_q;
		acc_n   = acc_q;
		hs_n    = hs_q;
		len_rst = 1'b0;
		enc_on  = 1'b0;
		enc_src = '0;
		hx      = hex_val(data_byte);
		acc_sh  = {acc_q[11:0], hx[3:0]};
		// hi is a high surrogate here, so the pair sum never goes negative
		cp_pair = PAIR_BASE + {1'b0, hs_q[9:0], 10'b0} + {5'b0, acc_sh};
		if (begin_req) begin
			act.mode = M_IDLE;
			if (data_byte == CH_QUOTE) begin
				act.mode = M_STR;
				len_rst  = 1'b1;
				acc_n    = '0;
				hs_n     = '0;
			end else begin
				act = err_act();
			end
		end else begin
			case (mode_q)
				M_STR: act = plain_act(data_byte);
				M_ESC: act = escape_act(data_byte);
				M_HI0, M_HI1, M_HI2, M_HI3: begin
					if (!hx[4]) begin
						act = err_act();
					end else begin
						acc_n = acc_sh;
						if (mode_q == M_HI3) begin
							if (acc_sh inside {[HI_SURR_LO:HI_SURR_HI]}) begin
								hs_n     = acc_sh;
								act.mode = M_WAIT_BS;
							end else begin
								enc_on   = 1'b1;
								enc_src  = {5'b0, acc_sh};
								act.mode = M_STR;
							end
						end else begin
							act.mode = mode_q + 4'd1;
						end
					end
				end
				M_WAIT_BS: begin
					if (data_byte == CH_BSLASH) begin
						act.mode = M_WAIT_U;
					end else begin
						enc_on  = 1'b1;
						enc_src = {5'b0, hs_q};
						act     = plain_act(data_byte);
					end
				end
				M_WAIT_U: begin
					if (data_byte == CH_U) begin
						acc_n    = '0;
						act.mode = M_LO0;
					end else begin
						enc_on  = 1'b1;
						enc_src = {5'b0, hs_q};
						act     = escape_act(data_byte);
					end
				end
				M_LO0, M_LO1, M_LO2, M_LO3: begin
					if (!hx[4]) begin
						act = err_act();
					end else begin
						acc_n = acc_sh;
						if (mode_q == M_LO3) begin
							enc_on   = 1'b1;
							enc_src  = cp_pair;
							act.mode = M_STR;
						end else begin
							act.mode = mode_q + 4'd1;
						end
					end
				end
				default: act.mode = M_IDLE;
			endcase
		end
		if (act.acc_clr)
			acc_n = '0;
		eot_err = end_of_text && (act.mode != M_IDLE);
	end

	assign enc    = utf8_enc(enc_src);
	assign enc_n  = enc_on ? enc.n : 3'd0;
	assign res_n  = enc_n + {2'b0, act.mid_v} + {2'b0, eot_err};
	assign data_n = enc_n + {2'b0, act.mid_v && (act.mid_st == ST_DATA)};

	// saturating length, the done count sees only the bytes before it
	assign done_sum = {1'b0, len_q} + (LENGTH_WIDTH+1)'(enc_n);
	assign next_sum = {1'b0, len_q} + (LENGTH_WIDTH+1)'(data_n);
	assign done_len = (done_sum > LEN_MAX) ? LEN_MAX[LENGTH_WIDTH-1:0]
	                                       : done_sum[LENGTH_WIDTH-1:0];
	assign len_n    = len_rst ? '0 :
	                  (next_sum > LEN_MAX) ? LEN_MAX[LENGTH_WIDTH-1:0]
	                                       : next_sum[LENGTH_WIDTH-1:0];
	assign done_ext = {{LEN_OUT_W{1'b0}}, done_len};

	always_comb begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			res_list[i] = '0;
			if (3'(i) < enc_n) begin
				res_list[i].data   = enc.b[i[1:0]];
				res_list[i].status = ST_DATA;
			end else if ((3'(i) == enc_n) && act.mid_v) begin
				res_list[i].data   = act.mid_data;
				res_list[i].status = act.mid_st;
				if (act.mid_st == ST_DONE)
					res_list[i].length = done_ext[LEN_OUT_W-1:0];
			end else begin
				res_list[i].status = ST_ERR;
			end
			res_list[i].last = (3'(i) == (res_n - 3'd1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_IDLE;
			acc_q       <= '0;
			hs_q        <= '0;
			len_q       <= '0;
			pend_cnt_q  <= '0;
			pend_rd_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				mode_q     <= eot_err ? M_IDLE : act.mode;
				acc_q      <= acc_n;
				hs_q       <= hs_n;
				len_q      <= len_n;
				pend_cnt_q <= CNT_W'(res_n);
				pend_rd_q  <= '0;
			end else if (pend_pop) begin
				pend_cnt_q <= pend_cnt_q - CNT_W'(1);
				pend_rd_q  <= pend_rd_q + PTR_W'(1);
			end
			if (pend_pop)
				out_valid_q <= 1'b1;
			else if (out_load)
				out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < MAX_RESULTS; i++)
				pend_q[i] <= res_list[i];
		end
		if (pend_pop)
			out_q <= pend_q[pend_rd_q];
	end

endmodule
